FILE: src/assert_macros.svh
// Assertion macros used by the route table RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: src/lprt_pkg.sv
// Package for the longest prefix route table: constants, payload and cell types.
// No dependencies.
package lprt_pkg;
	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_DEACT = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [31:0] gateway_in;
		logic [15:0] iface;
		logic [31:0] generation;
		logic [31:0] metric_in;
	} req_t;

	typedef struct packed {
		logic status;
		logic [31:0] hit_network;
		logic [31:0] hit_netmask;
		logic [31:0] hit_gateway;
		logic [15:0] hit_iface;
		logic [31:0] hit_generation;
		logic [31:0] hit_metric;
		logic [5:0] hit_prefix_len;
		logic [4:0] removed;
		logic [4:0] used_slots;
		logic [4:0] free_slots;
	} rsp_t;

	// Route held in one cell
	typedef struct packed {
		logic [31:0] network;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [15:0] iface;
		logic [31:0] generation;
		logic [31:0] metric;
		logic [5:0] prefix;
	} route_t;

	// Running state carried along the cell chain during one operation
	typedef struct packed {
		logic dup;
		logic placed;
		logic removed_one;
		logic found;
		logic [IDX_W-1:0] best_idx;
		logic [CNT_W-1:0] cleared;
		logic [CNT_W-1:0] used;
		route_t best;
	} chain_t;

	// Broadcast command to every cell for one pass
	typedef struct packed {
		logic check;
		logic commit;
		logic ok;
		logic [1:0] func;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [15:0] iface;
		logic [31:0] generation;
		route_t route;
	} cmd_t;
endpackage

FILE: src/lprt_cell.sv
// One route table slot: holds a route, folds it into the running pass state and
// hands that state, registered, to the next cell. Depends on lprt_pkg.
module lprt_cell (
	input logic clk,
	input logic arst_n,
	input logic [lprt_pkg::IDX_W-1:0] idx,
	input lprt_pkg::cmd_t cmd,
	input logic tok_in,
	input lprt_pkg::chain_t chain_in,
	output logic tok_out,
	output lprt_pkg::chain_t chain_out
);
	logic valid_q;
	lprt_pkg::route_t route_q;
	logic tok_q;
	lprt_pkg::chain_t chain_q;
	lprt_pkg::chain_t chain_nxt;
	logic exact;
	logic hit;
	logic better;
	logic deact;
	logic do_add;
	logic do_rem;
	logic do_deact;

	// Compare the stored route against the broadcast command
	always_comb begin
		exact = valid_q && route_q.network == cmd.addr && route_q.mask == cmd.mask
			&& route_q.iface == cmd.iface;
		hit = valid_q && ((cmd.addr & route_q.mask) == route_q.network);
		better = !chain_in.found || route_q.prefix > chain_in.best.prefix
			|| (route_q.prefix == chain_in.best.prefix
			&& route_q.metric < chain_in.best.metric);
		deact = valid_q && cmd.iface != 16'd0 && route_q.iface == cmd.iface
			&& (cmd.generation == 32'd0 || route_q.generation == cmd.generation);
		do_add = tok_in && cmd.commit && cmd.ok && cmd.func == lprt_pkg::FUNC_ADD
			&& !valid_q && !chain_in.placed;
		do_rem = tok_in && cmd.commit && cmd.func == lprt_pkg::FUNC_REMOVE
			&& cmd.iface != 16'd0 && exact && !chain_in.removed_one;
		do_deact = tok_in && cmd.commit && cmd.func == lprt_pkg::FUNC_DEACT && deact;
		chain_nxt = chain_in;
		if (cmd.check && exact)
			chain_nxt.dup = 1'b1;
		if (do_add)
			chain_nxt.placed = 1'b1;
		if (do_rem)
			chain_nxt.removed_one = 1'b1;
		if (cmd.commit && cmd.func == lprt_pkg::FUNC_LOOKUP && hit && better) begin
			chain_nxt.found = 1'b1;
			chain_nxt.best_idx = idx;
			chain_nxt.best = route_q;
		end
		if (do_deact)
			chain_nxt.cleared = chain_in.cleared + lprt_pkg::CNT_W'(1);
		// Count slots still valid after this operation
		if ((valid_q && !do_rem && !do_deact) || do_add)
			chain_nxt.used = chain_in.used + lprt_pkg::CNT_W'(1);
	end

	// Hold valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (do_add) begin
			valid_q <= 1'b1;
		end else if (do_rem || do_deact) begin
			valid_q <= 1'b0;
		end
	end

	// Hold route fields; remove clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_q <= '0;
		end else if (do_add) begin
			route_q <= cmd.route;
		end else if (do_rem) begin
			route_q <= '0;
		end
	end

	// Advance the token and the pass state to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			chain_q <= '0;
		end else begin
			tok_q <= tok_in;
			if (tok_in)
				chain_q <= chain_nxt;
		end
	end

	assign tok_out = tok_q;
	assign chain_out = chain_q;
endmodule

FILE: src/longest_prefix_route_table.sv
// Longest prefix route table: a request is registered, then a token walks the
// row of slot cells twice, one cell per cycle. The first pass looks for a
// duplicate route, the second applies the operation and gathers the result.
// The result is held in an output register until taken, and the next request
// is accepted only once the table is idle and that register is empty.
// Depends on lprt_pkg, lprt_cell and assert_macros.svh.
`include "assert_macros.svh"
module longest_prefix_route_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lprt_pkg::req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output lprt_pkg::rsp_t out_data
);
	typedef enum logic [1:0] {IDLE, CHECK, APPLY} state_t;
	state_t state_q;
	lprt_pkg::req_t req_q;
	logic dup_q;
	logic start_q;
	logic [5:0] plen;
	logic mask_ok;
	lprt_pkg::cmd_t cmd;
	lprt_pkg::chain_t chain [lprt_pkg::ENTRIES+1];
	logic tok [lprt_pkg::ENTRIES+1];
	lprt_pkg::rsp_t rsp;
	logic [31:0] inv;

	assign in_ready = state_q == IDLE && !out_valid;

	// Mask check and prefix length
	always_comb begin
		inv = ~req_q.mask;
		mask_ok = (inv & (inv + 32'd1)) == 32'd0;
		plen = 6'($countones(req_q.mask));
	end

	// Build broadcast command
	always_comb begin
		cmd.check = state_q == CHECK;
		cmd.commit = state_q == APPLY;
		cmd.ok = req_q.iface != 16'd0 && mask_ok && (req_q.addr & ~req_q.mask) == 32'd0
			&& !dup_q;
		cmd.func = req_q.func;
		cmd.addr = req_q.addr;
		cmd.mask = req_q.mask;
		cmd.iface = req_q.iface;
		cmd.generation = req_q.generation;
		cmd.route.network = req_q.addr;
		cmd.route.mask = req_q.mask;
		cmd.route.gateway = req_q.gateway_in;
		cmd.route.iface = req_q.iface;
		cmd.route.generation = req_q.generation;
		cmd.route.metric = req_q.metric_in;
		cmd.route.prefix = plen;
	end

	assign chain[0] = '0;
	assign tok[0] = start_q;

	for (genvar g = 0; g < lprt_pkg::ENTRIES; g++) begin : g_cell
		lprt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.idx(lprt_pkg::IDX_W'(g)),
			.cmd(cmd),
			.tok_in(tok[g]),
			.chain_in(chain[g]),
			.tok_out(tok[g+1]),
			.chain_out(chain[g+1])
		);
	end

	// Form result from chain tail
	always_comb begin
		lprt_pkg::chain_t t;
		t = chain[lprt_pkg::ENTRIES];
		rsp = '0;
		rsp.used_slots = 5'(t.used);
		rsp.free_slots = 5'(lprt_pkg::CNT_W'(lprt_pkg::ENTRIES) - t.used);
		unique case (lprt_pkg::func_t'(req_q.func))
			lprt_pkg::FUNC_ADD: rsp.status = !t.placed;
			lprt_pkg::FUNC_REMOVE: rsp.status = !t.removed_one;
			lprt_pkg::FUNC_LOOKUP: begin
				rsp.status = !t.found;
				if (t.found) begin
					rsp.hit_network = t.best.network;
					rsp.hit_netmask = t.best.mask;
					rsp.hit_gateway = t.best.gateway;
					rsp.hit_iface = t.best.iface;
					rsp.hit_generation = t.best.generation;
					rsp.hit_metric = t.best.metric;
					rsp.hit_prefix_len = t.best.prefix;
				end
			end
			lprt_pkg::FUNC_DEACT: begin
				rsp.status = req_q.iface == 16'd0;
				rsp.removed = 5'(t.cleared);
			end
			default: rsp.status = 1'b1;
		endcase
	end

	// Sequence request through check and apply passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			start_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
			dup_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (out_valid && out_ready)
						out_valid <= 1'b0;
					start_q <= in_valid && in_ready;
					if (in_valid && in_ready)
						state_q <= CHECK;
				end
				CHECK: begin
					start_q <= tok[lprt_pkg::ENTRIES];
					if (tok[lprt_pkg::ENTRIES]) begin
						dup_q <= chain[lprt_pkg::ENTRIES].dup;
						state_q <= APPLY;
					end
				end
				APPLY: begin
					start_q <= 1'b0;
					if (tok[lprt_pkg::ENTRIES]) begin
						out_valid <= 1'b1;
						out_data <= rsp;
						state_q <= IDLE;
					end
				end
				default: begin
					start_q <= 1'b0;
					state_q <= IDLE;
				end
			endcase
		end
	end

	// Capture request payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			req_q <= in_data;
	end

	`ASSERT_CLK(a_busy_not_ready, clk, arst_n, (state_q != IDLE) |-> !in_ready, "ready while busy")
	`ASSERT_CLK(a_apply_valid, clk, arst_n, (state_q == APPLY && tok[lprt_pkg::ENTRIES]) |=> out_valid, "no result after apply")
	`ASSERT_CLK(a_counts_sum, clk, arst_n, out_valid |-> (6'(out_data.used_slots) + 6'(out_data.free_slots) == 6'(lprt_pkg::ENTRIES)), "counts mismatch")
endmodule

FILE: sim/route_table_checker.sv
// Checker for the longest prefix route table: watches both channels, predicts
// each response from a private copy of the table and compares field by field.
// Depends on lprt_pkg.
`timescale 1ns / 1ps
module route_table_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input lprt_pkg::req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input lprt_pkg::rsp_t out_data,
	output int fail_count,
	output int pending
);
	logic [lprt_pkg::ENTRIES-1:0] slot_on;
	lprt_pkg::route_t slot_route [lprt_pkg::ENTRIES];
	logic [4:0] shadow_count;
	lprt_pkg::rsp_t rsp_queue [$];

	// Check for a run of leading ones and return its length
	function automatic logic mask_prefix(input logic [31:0] m, output logic [5:0] len);
		logic [31:0] inv;
		inv = ~m;
		len = 6'd0;
		for (int b = 31; b >= 0; b--) begin
			if (!m[b]) break;
			len++;
		end
		return (inv & (inv + 32'd1)) == 32'd0;
	endfunction

	// Apply one request to the shadow table and return the response it yields
	function automatic lprt_pkg::rsp_t apply_request(input lprt_pkg::req_t r);
		lprt_pkg::rsp_t o;
		logic [5:0] len;
		logic ok;
		logic found;
		int best;
		int used;
		o = '0;
		o.status = 1'b1;
		found = 1'b0;
		best = 0;
		used = 0;
		case (lprt_pkg::func_t'(r.func))
			lprt_pkg::FUNC_ADD: begin
				ok = r.iface != 16'd0 && mask_prefix(r.mask, len)
					&& (r.addr & ~r.mask) == 32'd0;
				for (int i = 0; i < lprt_pkg::ENTRIES; i++)
					if (ok && slot_on[i] && slot_route[i].network == r.addr &&
						slot_route[i].mask == r.mask && slot_route[i].iface == r.iface)
						ok = 1'b0;
				for (int i = 0; i < lprt_pkg::ENTRIES; i++) begin
					if (ok && !slot_on[i]) begin
						slot_on[i] = 1'b1;
						slot_route[i] = '{r.addr, r.mask, r.gateway_in, r.iface,
							r.generation, r.metric_in, len};
						shadow_count++;
						o.status = 1'b0;
						ok = 1'b0;
					end
				end
			end
			lprt_pkg::FUNC_REMOVE: begin
				for (int i = 0; i < lprt_pkg::ENTRIES; i++) begin
					if (r.iface != 16'd0 && o.status && slot_on[i] &&
						slot_route[i].network == r.addr && slot_route[i].mask == r.mask &&
						slot_route[i].iface == r.iface) begin
						slot_on[i] = 1'b0;
						slot_route[i] = '0;
						if (shadow_count != 5'd0) shadow_count--;
						o.status = 1'b0;
					end
				end
			end
			lprt_pkg::FUNC_LOOKUP: begin
				for (int i = 0; i < lprt_pkg::ENTRIES; i++) begin
					if (!slot_on[i] || (r.addr & slot_route[i].mask) != slot_route[i].network)
						continue;
					if (!found || slot_route[i].prefix > slot_route[best].prefix ||
						(slot_route[i].prefix == slot_route[best].prefix &&
						slot_route[i].metric < slot_route[best].metric)) begin
						best = i;
						found = 1'b1;
					end
				end
				if (found) begin
					o.status = 1'b0;
					o.hit_network = slot_route[best].network;
					o.hit_netmask = slot_route[best].mask;
					o.hit_gateway = slot_route[best].gateway;
					o.hit_iface = slot_route[best].iface;
					o.hit_generation = slot_route[best].generation;
					o.hit_metric = slot_route[best].metric;
					o.hit_prefix_len = slot_route[best].prefix;
				end
			end
			default: begin
				if (r.iface != 16'd0) begin
					o.status = 1'b0;
					for (int i = 0; i < lprt_pkg::ENTRIES; i++) begin
						if (!slot_on[i] || slot_route[i].iface != r.iface ||
							(r.generation != 32'd0 && slot_route[i].generation != r.generation))
							continue;
						slot_on[i] = 1'b0;
						if (shadow_count != 5'd0) shadow_count--;
						o.removed++;
					end
				end
			end
		endcase
		for (int i = 0; i < lprt_pkg::ENTRIES; i++) used += int'(slot_on[i]);
		o.used_slots = shadow_count;
		o.free_slots = 5'(lprt_pkg::ENTRIES - used);
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Predict on each request transfer, compare on each response transfer
	always @(posedge clk or negedge arst_n) begin
		lprt_pkg::rsp_t want;
		if (!arst_n) begin
			slot_on = '0;
			for (int i = 0; i < lprt_pkg::ENTRIES; i++) slot_route[i] = '0;
			shadow_count = 5'd0;
			fail_count = 0;
			rsp_queue.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready) rsp_queue.push_back(apply_request(in_data));
			if (out_valid && out_ready) begin
				if (rsp_queue.size() == 0) begin
					$display("unexpected response at %0t", $realtime);
					fail_count++;
				end else begin
					want = rsp_queue.pop_front();
					if (out_data.status !== want.status)
						report("status", 32'(out_data.status), 32'(want.status));
					if (out_data.hit_network !== want.hit_network)
						report("hit_network", out_data.hit_network, want.hit_network);
					if (out_data.hit_netmask !== want.hit_netmask)
						report("hit_netmask", out_data.hit_netmask, want.hit_netmask);
					if (out_data.hit_gateway !== want.hit_gateway)
						report("hit_gateway", out_data.hit_gateway, want.hit_gateway);
					if (out_data.hit_iface !== want.hit_iface)
						report("hit_iface", 32'(out_data.hit_iface), 32'(want.hit_iface));
					if (out_data.hit_generation !== want.hit_generation)
						report("hit_generation", out_data.hit_generation, want.hit_generation);
					if (out_data.hit_metric !== want.hit_metric)
						report("hit_metric", out_data.hit_metric, want.hit_metric);
					if (out_data.hit_prefix_len !== want.hit_prefix_len)
						report("hit_prefix_len", 32'(out_data.hit_prefix_len),
							32'(want.hit_prefix_len));
					if (out_data.removed !== want.removed)
						report("removed", 32'(out_data.removed), 32'(want.removed));
					if (out_data.used_slots !== want.used_slots)
						report("used_slots", 32'(out_data.used_slots), 32'(want.used_slots));
					if (out_data.free_slots !== want.free_slots)
						report("free_slots", 32'(out_data.free_slots), 32'(want.free_slots));
				end
			end
			pending = rsp_queue.size();
		end
	end
endmodule

FILE: sim/tb_longest_prefix_route_table.sv
// Testbench top for the longest prefix route table: directed and random
// route operations with random idling on both channels.
// Depends on lprt_pkg, longest_prefix_route_table and route_table_checker.
`timescale 1ns / 1ps
module tb_longest_prefix_route_table;
	localparam int RANDOM_OPS = 1130;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lprt_pkg::req_t in_data;
	logic out_valid;
	logic out_ready;
	lprt_pkg::rsp_t out_data;
	int fail_count;
	int pending;
	longint cycles;

	// Small pool of networks so adds, removes and lookups collide often
	logic [31:0] net_pool [8];
	logic [5:0] len_pool [8];
	logic [15:0] iface_pool [4];
	logic [31:0] gen_pool [3];

	longest_prefix_route_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	route_table_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one, sometimes none
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [31:0] len_mask(input logic [5:0] len);
		return (len == 6'd0) ? 32'd0 : ~32'd0 << (32 - len);
	endfunction

	// Randomly stall the response side, now and then for a long stretch
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < 20) begin
				out_ready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Hold the request until its transfer, then idle for a random gap
	task automatic send(input lprt_pkg::req_t r);
		int g;
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic lprt_pkg::req_t make_req(input lprt_pkg::func_t f,
		input logic [31:0] a, input logic [31:0] m, input logic [15:0] ifc,
		input logic [31:0] g, input logic [31:0] met);
		lprt_pkg::req_t r;
		r.func = f;
		r.addr = a;
		r.mask = m;
		r.gateway_in = $urandom;
		r.iface = ifc;
		r.generation = g;
		r.metric_in = met;
		return r;
	endfunction

	// Build a random request: mostly well-formed routes from the pools
	function automatic lprt_pkg::req_t random_req();
		lprt_pkg::req_t r;
		int k;
		int sel;
		k = $urandom_range(0, 7);
		r = make_req(lprt_pkg::func_t'($urandom_range(0, 3)), net_pool[k],
			len_mask(len_pool[k]), iface_pool[$urandom_range(0, 3)],
			gen_pool[$urandom_range(0, 2)], $urandom_range(0, 3));
		sel = $urandom_range(0, 99);
		if (r.func == lprt_pkg::FUNC_ADD && sel < 25) r.func = lprt_pkg::FUNC_LOOKUP;
		if (r.func == lprt_pkg::FUNC_LOOKUP)
			r.addr = net_pool[k] | ($urandom & ~len_mask(len_pool[k]));
		if (sel >= 90) begin
			r.addr = $urandom;
			r.mask = (sel >= 95) ? $urandom : len_mask(6'($urandom_range(0, 32)));
			r.iface = 16'($urandom);
			r.generation = $urandom;
			r.metric_in = $urandom;
		end
		if (sel == 89) r.iface = 16'd0;
		return r;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		for (int i = 0; i < 8; i++) begin
			len_pool[i] = (i == 0) ? 6'd0 : (i == 7) ? 6'd32 : 6'($urandom_range(1, 31));
			net_pool[i] = $urandom & len_mask(len_pool[i]);
		end
		// Nest a few prefixes so longest-match ordering matters
		net_pool[2] = net_pool[1] & len_mask(len_pool[2]);
		net_pool[7] = net_pool[3] | ($urandom & ~len_mask(len_pool[3]));
		for (int i = 0; i < 4; i++)
			iface_pool[i] = (i == 3) ? 16'hffff : 16'($urandom_range(1, 5));
		gen_pool[0] = 32'd0;
		gen_pool[1] = 32'd1;
		gen_pool[2] = 32'hffff_ffff;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: rejects, extremes, ties, remove, deactivate
		send(make_req(lprt_pkg::FUNC_LOOKUP, 32'h0a00_0001, 0, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 16'd0, 1, 5));
		send(make_req(lprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_ff00, 16'd1, 1, 5));
		send(make_req(lprt_pkg::FUNC_ADD, 32'h0a00_0001, 32'hff00_0000, 16'd1, 1, 5));
		send(make_req(lprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 16'd1, 1, 5));
		send(make_req(lprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 16'd1, 2, 9));
		send(make_req(lprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 16'd2, 2, 3));
		send(make_req(lprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 16'd3, 2, 3));
		send(make_req(lprt_pkg::FUNC_ADD, 0, 0, 16'hffff, 32'hffff_ffff, 32'hffff_ffff));
		send(make_req(lprt_pkg::FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 16'd1, 7, 0));
		send(make_req(lprt_pkg::FUNC_LOOKUP, 32'h0a01_0203, 0, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_LOOKUP, 32'hffff_ffff, 0, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_LOOKUP, 32'h0b00_0000, 0, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_REMOVE, 32'h0a00_0000, 32'hff00_0000, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_REMOVE, 32'h0a00_0000, 32'hff00_0000, 16'd2, 0, 0));
		send(make_req(lprt_pkg::FUNC_REMOVE, 32'h0a00_0000, 32'hff00_0000, 16'd2, 0, 0));
		send(make_req(lprt_pkg::FUNC_LOOKUP, 32'h0a01_0203, 0, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_DEACT, 0, 0, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_DEACT, 0, 0, 16'd1, 2, 0));
		send(make_req(lprt_pkg::FUNC_DEACT, 0, 0, 16'hffff, 0, 0));
		send(make_req(lprt_pkg::FUNC_DEACT, 0, 0, 16'd1, 0, 0));
		send(make_req(lprt_pkg::FUNC_DEACT, 0, 0, 16'd9, 0, 0));
		for (int i = 0; i < 17; i++)
			send(make_req(lprt_pkg::FUNC_ADD, i << 8, 32'hffff_ff00, 16'd4, 0, i));
		send(make_req(lprt_pkg::FUNC_LOOKUP, 32'h0000_0305, 0, 16'd0, 0, 0));
		send(make_req(lprt_pkg::FUNC_DEACT, 0, 0, 16'd4, 0, 0));

		// Random operations on the pooled routes
		for (int n = 0; n < RANDOM_OPS; n++) send(random_req());
		in_valid <= 1'b0;

		// Drain outstanding responses
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
